@@ sv/isoline_cell_segment_extractor_defines.svh @@
// Assertion macros shared by the isoline cell segment extractor RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ISOLINE_CELL_SEGMENT_EXTRACTOR_DEFINES_SVH
`define ISOLINE_CELL_SEGMENT_EXTRACTOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ise_pkg.sv @@
// Package for the isoline cell segment extractor: widths, corner codes, segment table.
// No dependencies.
package ise_pkg;
    localparam int VALUE_BITS_DEF      = 24;
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int FRACTION_BITS_DEF   = 16;
    localparam int CW                  = 24;
    localparam logic [23:0] LEVEL_RESET = 24'sd101300;
    localparam logic [0:0] REG_LEVEL   = 1'b0;

    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BL = 2'd2,
        CORNER_BR = 2'd3
    } corner_t;

    typedef struct packed {
        logic [1:0] n;
        corner_t    p0, q0, r0, s0, p1, q1, r1, s1;
    } seg_entry_t;

    function automatic seg_entry_t seg_lookup(input logic [3:0] code);
        seg_entry_t e;
        e = '{2'd0, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL,
              CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
        unique case (code)
            4'd1, 4'd14: e = '{2'd1, CORNER_TL, CORNER_TR, CORNER_TL, CORNER_BL,
                               CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd2, 4'd13: e = '{2'd1, CORNER_TL, CORNER_TR, CORNER_TR, CORNER_BR,
                               CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd3, 4'd12: e = '{2'd1, CORNER_TL, CORNER_BL, CORNER_TR, CORNER_BR,
                               CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd4, 4'd11: e = '{2'd1, CORNER_TL, CORNER_BL, CORNER_BL, CORNER_BR,
                               CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd5, 4'd10: e = '{2'd1, CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BR,
                               CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd6: e = '{2'd2, CORNER_TL, CORNER_TR, CORNER_TR, CORNER_BR,
                        CORNER_TL, CORNER_BL, CORNER_BL, CORNER_BR};
            4'd7, 4'd8: e = '{2'd1, CORNER_BL, CORNER_BR, CORNER_TR, CORNER_BR,
                              CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
            4'd9: e = '{2'd2, CORNER_TL, CORNER_TR, CORNER_TL, CORNER_BL,
                        CORNER_TR, CORNER_BR, CORNER_BL, CORNER_BR};
            default: e = '{2'd0, CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL,
                           CORNER_TL, CORNER_TL, CORNER_TL, CORNER_TL};
        endcase
        return e;
    endfunction
endpackage

@@ sv/ise_divider.sv @@
// Pipelined restoring divider: one quotient bit per stage for the edge fraction.
// Depends on ise_pkg. Carries sideband data alongside; stalls with en.
module ise_divider
    import ise_pkg::*;
#(
    parameter int NB = 26,
    parameter int QB = 16,
    parameter int SB = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] num,
    input  logic [NB-1:0] den,
    input  logic [SB-1:0] side_in,
    output logic          out_valid,
    output logic [QB:0]   quot,
    output logic [SB-1:0] side_out
);
    logic [QB:0]    v_reg;
    logic [NB:0]    rem_reg  [QB+1];
    logic [NB-1:0]  den_reg  [QB+1];
    logic [QB:0]    q_reg    [QB+1];
    logic [SB-1:0]  sd_reg   [QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[QB-1:0], in_valid};
    end

    // first stage takes the integer bit: num <= den, so it is set only when num == den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= (num >= den) ? {1'b0, num - den} : {1'b0, num};
            den_reg[0] <= den;
            q_reg[0]   <= {{QB{1'b0}}, num >= den};
            sd_reg[0]  <= side_in;
            for (int k = 1; k <= QB; k++)
            begin
                logic [NB+1:0] t;
                t = {rem_reg[k-1], 1'b0} - {2'b0, den_reg[k-1]};
                if (!t[NB+1])
                begin
                    rem_reg[k] <= t[NB:0];
                    q_reg[k]   <= {q_reg[k-1][QB-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k-1][NB-1:0], 1'b0};
                    q_reg[k]   <= {q_reg[k-1][QB-1:0], 1'b0};
                end
                den_reg[k] <= den_reg[k-1];
                sd_reg[k]  <= sd_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign quot      = q_reg[QB];
    assign side_out  = sd_reg[QB];
endmodule

@@ sv/isoline_cell_segment_extractor.sv @@
// Top level of the isoline cell segment extractor: classify, divide, interpolate.
// Depends on ise_pkg, ise_divider and the assertion macro header.
//   channel | signals                                   | dir
//   cell    | cell_valid, cell_ready, value_*, x_*, y_* | in
//   segment | seg_valid, seg_ready, start_*, end_*, last| out
//   config  | psel, penable, pwrite, paddr, pwdata      | in
// One cell enters per cycle unless stalled; a saddle holds it for its second segment.
// seg_valid rises once the accepted cell has passed stages 1 and 2, the bit-per-stage
// divider pipeline, stage M and the output register; a saddle's second segment follows.
// Reset clears all valid bits and sets level to 101300.
// The whole pipeline stalls while the output register holds a word and seg_ready is low.
`include "isoline_cell_segment_extractor_defines.svh"
module isoline_cell_segment_extractor
    import ise_pkg::*;
#(
    parameter int VALUE_BITS      = VALUE_BITS_DEF,
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  cell_valid,
    output logic                  cell_ready,
    input  logic [VALUE_BITS-1:0] value_top_left,
    input  logic [VALUE_BITS-1:0] value_top_right,
    input  logic [VALUE_BITS-1:0] value_bottom_left,
    input  logic [VALUE_BITS-1:0] value_bottom_right,
    input  logic [CW-1:0]         x_left,
    input  logic [CW-1:0]         x_right,
    input  logic [CW-1:0]         y_top,
    input  logic [CW-1:0]         y_bottom,
    output logic                  seg_valid,
    input  logic                  seg_ready,
    output logic [CW-1:0]         start_x,
    output logic [CW-1:0]         start_y,
    output logic [CW-1:0]         end_x,
    output logic [CW-1:0]         end_y,
    output logic                  last_of_cell
);
    localparam int FB = FRACTION_BITS;
    localparam int NB = VALUE_BITS + 2;

    logic signed [VALUE_BITS-1:0] level_reg;
    logic en, wr;
    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = 32'(signed'(level_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= VALUE_BITS'(signed'(LEVEL_RESET));
        else if (wr && paddr[1:0] == {REG_LEVEL, 1'b0})
            level_reg <= pwdata[VALUE_BITS-1:0];
    end

    // Stage 0: classify, issue segment 0 then 1
    logic signed [VALUE_BITS-1:0] v [4];
    logic [3:0] code;
    seg_entry_t ent;
    logic half_reg;
    assign v[0] = value_top_left;
    assign v[1] = value_top_right;
    assign v[2] = value_bottom_left;
    assign v[3] = value_bottom_right;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            code[k] = v[k] > level_reg;
    end
    assign ent = seg_lookup(code);

    logic issue, cur_last;
    corner_t ep, eq, er, es;
    assign issue = cell_valid && ent.n != 2'd0;
    assign cur_last = !(ent.n == 2'd2 && !half_reg);
    assign cell_ready = en && (cur_last || ent.n == 2'd0 || !cell_valid);
    assign ep = half_reg ? ent.p1 : ent.p0;
    assign eq = half_reg ? ent.q1 : ent.q0;
    assign er = half_reg ? ent.r1 : ent.r0;
    assign es = half_reg ? ent.s1 : ent.s0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= 1'b0;
        else if (en && issue)
            half_reg <= !cur_last;
    end

    // Stage 1: operands for both endpoints
    logic s1_v_reg;
    logic signed [NB-1:0] n_reg [2], d_reg [2];
    logic signed [CW-1:0] c_reg [2][4];
    logic s1_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= issue;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= NB'(level_reg) - NB'(v[ep]);
            d_reg[0] <= NB'(v[eq]) - NB'(v[ep]);
            n_reg[1] <= NB'(level_reg) - NB'(v[er]);
            d_reg[1] <= NB'(v[es]) - NB'(v[er]);
            c_reg[0][0] <= ep[0] ? x_right : x_left;
            c_reg[0][1] <= eq[0] ? x_right : x_left;
            c_reg[0][2] <= ep[1] ? y_bottom : y_top;
            c_reg[0][3] <= eq[1] ? y_bottom : y_top;
            c_reg[1][0] <= er[0] ? x_right : x_left;
            c_reg[1][1] <= es[0] ? x_right : x_left;
            c_reg[1][2] <= er[1] ? y_bottom : y_top;
            c_reg[1][3] <= es[1] ? y_bottom : y_top;
            s1_last_reg <= cur_last;
        end
    end

    // Stage 2: magnitudes, midpoint test, coordinate deltas
    logic s2_v_reg;
    logic [NB-1:0] an_reg [2], ad_reg [2];
    logic mid_reg [2], neg_reg [2];
    logic signed [CW-1:0] a_reg [4];
    logic signed [CW:0] dl_reg [4];
    logic s2_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int e = 0; e < 2; e++)
            begin
                logic [NB-1:0] an, ad;
                an = n_reg[e][NB-1] ? -n_reg[e] : n_reg[e];
                ad = d_reg[e][NB-1] ? -d_reg[e] : d_reg[e];
                an_reg[e]  <= an;
                ad_reg[e]  <= ad;
                mid_reg[e] <= (ad == '0) || (an > ad);
                neg_reg[e] <= n_reg[e][NB-1] != d_reg[e][NB-1];
                a_reg[2*e]    <= c_reg[e][0];
                a_reg[2*e+1]  <= c_reg[e][2];
                dl_reg[2*e]   <= (CW+1)'(c_reg[e][1]) - (CW+1)'(c_reg[e][0]);
                dl_reg[2*e+1] <= (CW+1)'(c_reg[e][3]) - (CW+1)'(c_reg[e][2]);
            end
            s2_last_reg <= s1_last_reg;
        end
    end

    // Divider pipeline for both fractions
    localparam int SB = 4 * CW + 4 * (CW + 1) + 4;
    logic [SB-1:0] side_in, side_out;
    logic dv0, dv1;
    logic [FB:0] q0, q1;
    logic slast;
    assign side_in = {a_reg[0], a_reg[1], a_reg[2], a_reg[3],
                      dl_reg[0], dl_reg[1], dl_reg[2], dl_reg[3],
                      mid_reg[0], neg_reg[0], mid_reg[1], neg_reg[1]};
    ise_divider #(.NB(NB), .QB(FB), .SB(SB)) u_div0 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_reg),
        .num(mid_reg[0] ? NB'(0) : an_reg[0]), .den(mid_reg[0] ? NB'(1) : ad_reg[0]),
        .side_in(side_in), .out_valid(dv0), .quot(q0), .side_out(side_out));
    ise_divider #(.NB(NB), .QB(FB), .SB(1)) u_div1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_reg),
        .num(mid_reg[1] ? NB'(0) : an_reg[1]), .den(mid_reg[1] ? NB'(1) : ad_reg[1]),
        .side_in(s2_last_reg), .out_valid(dv1), .quot(q1), .side_out(slast));

    // Stage M: multiply magnitudes
    logic signed [CW-1:0] sa [4];
    logic signed [CW:0] sd [4];
    logic smid [2], sneg [2];
    assign {sa[0], sa[1], sa[2], sa[3], sd[0], sd[1], sd[2], sd[3],
            smid[0], sneg[0], smid[1], sneg[1]} = side_out;

    logic m_v_reg;
    logic [CW+FB+1:0] p_reg [4];
    logic pneg_reg [4];
    logic signed [CW-1:0] ma_reg [4];
    logic m_last_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_v_reg <= 1'b0;
        else if (en)
            m_v_reg <= dv0;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic [FB:0] fm;
                logic [CW:0] dm;
                logic fz, fn;
                fm = (k < 2) ? (smid[0] ? (FB+1)'(1) << (FB-1) : q0)
                             : (smid[1] ? (FB+1)'(1) << (FB-1) : q1);
                fn = (k < 2) ? (!smid[0] && sneg[0]) : (!smid[1] && sneg[1]);
                fz = fm == '0;
                dm = sd[k][CW] ? -sd[k] : sd[k];
                p_reg[k]    <= (CW+FB+2)'(dm) * (CW+FB+2)'(fm);
                pneg_reg[k] <= (sd[k][CW] != (fn && !fz)) && !fz;
                ma_reg[k]   <= sa[k];
            end
            m_last_reg <= slast;
        end
    end

    // Stage A: shift, sign, add, saturate into output register
    logic o_v_reg;
    logic [CW-1:0] o_reg [4];
    logic o_last_reg;
    assign en = !o_v_reg || seg_ready;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= m_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                logic signed [CW+2:0] t, r;
                t = signed'({1'b0, p_reg[k][CW+FB+1:FB]});
                if (pneg_reg[k])
                    t = -t;
                r = (CW+3)'(ma_reg[k]) + t;
                if (r > (CW+3)'((1 << (CW-1)) - 1))
                    o_reg[k] <= CW'((1 << (CW-1)) - 1);
                else if (r < -(CW+3)'(1 << (CW-1)))
                    o_reg[k] <= CW'(1 << (CW-1));
                else
                    o_reg[k] <= r[CW-1:0];
            end
            o_last_reg <= m_last_reg;
        end
    end

    assign seg_valid    = o_v_reg;
    assign start_x      = o_reg[0];
    assign start_y      = o_reg[1];
    assign end_x        = o_reg[2];
    assign end_y        = o_reg[3];
    assign last_of_cell = o_last_reg;

    `ASSERT_NEXT(a_hold, clk, rst_n, seg_valid && !seg_ready, seg_valid && $stable(start_x))
    `ASSERT_IMPL(a_div_sync, clk, rst_n, 1'b1, dv0 == dv1)
    `ASSERT_NEXT(a_half, clk, rst_n, half_reg && en && issue, !half_reg)
endmodule
